// ===== rtl/shc_pkg.sv =====
// Shared types and constants of the stall homing calibrator.
`default_nettype none

package shc_pkg;

  // Motor slots: yaw, left pitch, right pitch
  localparam int unsigned MotorCount = 3;
  localparam int unsigned MotorYaw    = 0;
  localparam int unsigned MotorPitchL = 1;
  localparam int unsigned MotorPitchR = 2;

  // Field widths
  localparam int unsigned TorqueW    = 15;
  localparam int unsigned SpeedW     = 16;
  localparam int unsigned AngleW     = 32;
  localparam int unsigned TorqueLimW = 14;
  localparam int unsigned StillLimW  = 15;
  localparam int unsigned CountW     = 6;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned CfgDataW   = 15;

  // Stall ticks needed before the angle is taken as zero
  localparam int unsigned StallTicksDefault = 50;

  // Reset value of the stillness limit
  localparam logic [StillLimW-1:0] StillLimReset = StillLimW'(32);

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_TORQUE_YAW     = 2'd0,
    CFG_TORQUE_PITCH_L = 2'd1,
    CFG_TORQUE_PITCH_R = 2'd2,
    CFG_STILL_LIMIT    = 2'd3
  } cfg_idx_e;

  // One motor's sample out of an input word
  typedef struct packed {
    logic                     enabled;
    logic signed [TorqueW-1:0] torque;
    logic signed [SpeedW-1:0]  speed;
    logic signed [AngleW-1:0]  angle;
  } motor_in_t;

  // Per-motor control from the top level
  typedef struct packed {
    logic step;
    logic calibrating;
  } motor_ctl_t;

  // Per-motor visible state
  typedef struct packed {
    logic                     homed;
    logic                     openloop;
    logic signed [AngleW-1:0] offset;
  } motor_state_t;

endpackage

`default_nettype wire

// ===== rtl/shc_if.sv =====
// Valid/ready channel interfaces for the input and result words.
`default_nettype none

interface shc_in_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 enabled_yaw;
  logic signed [shc_pkg::TorqueW-1:0]   torque_yaw;
  logic signed [shc_pkg::SpeedW-1:0]    speed_yaw;
  logic signed [shc_pkg::AngleW-1:0]    angle_yaw;
  logic                                 enabled_pitch_left;
  logic signed [shc_pkg::TorqueW-1:0]   torque_pitch_left;
  logic signed [shc_pkg::SpeedW-1:0]    speed_pitch_left;
  logic signed [shc_pkg::AngleW-1:0]    angle_pitch_left;
  logic                                 enabled_pitch_right;
  logic signed [shc_pkg::TorqueW-1:0]   torque_pitch_right;
  logic signed [shc_pkg::SpeedW-1:0]    speed_pitch_right;
  logic signed [shc_pkg::AngleW-1:0]    angle_pitch_right;

  modport source (
    output valid, enabled_yaw, torque_yaw, speed_yaw, angle_yaw,
           enabled_pitch_left, torque_pitch_left, speed_pitch_left, angle_pitch_left,
           enabled_pitch_right, torque_pitch_right, speed_pitch_right, angle_pitch_right,
    input  ready
  );
  modport sink (
    input  valid, enabled_yaw, torque_yaw, speed_yaw, angle_yaw,
           enabled_pitch_left, torque_pitch_left, speed_pitch_left, angle_pitch_left,
           enabled_pitch_right, torque_pitch_right, speed_pitch_right, angle_pitch_right,
    output ready
  );
endinterface

interface shc_out_if;
  logic                               valid;
  logic                               ready;
  logic                               in_normal;
  logic                               homed_yaw;
  logic                               homed_pitch_left;
  logic                               homed_pitch_right;
  logic                               openloop_yaw;
  logic                               openloop_pitch_left;
  logic                               openloop_pitch_right;
  logic signed [shc_pkg::AngleW-1:0]  offset_yaw;
  logic signed [shc_pkg::AngleW-1:0]  offset_pitch_left;
  logic signed [shc_pkg::AngleW-1:0]  offset_pitch_right;

  modport source (
    output valid, in_normal, homed_yaw, homed_pitch_left, homed_pitch_right,
           openloop_yaw, openloop_pitch_left, openloop_pitch_right,
           offset_yaw, offset_pitch_left, offset_pitch_right,
    input  ready
  );
  modport sink (
    input  valid, in_normal, homed_yaw, homed_pitch_left, homed_pitch_right,
           openloop_yaw, openloop_pitch_left, openloop_pitch_right,
           offset_yaw, offset_pitch_left, offset_pitch_right,
    output ready
  );
endinterface

`default_nettype wire

// ===== rtl/shc_motor.sv =====
// Per-motor stall detector, counter and zero offset latch.
`default_nettype none

module shc_motor #(
  parameter int unsigned StallTicks = shc_pkg::StallTicksDefault
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire shc_pkg::motor_ctl_t                ctl_i,
  input  wire shc_pkg::motor_in_t                 sample_i,
  input  wire logic [shc_pkg::TorqueLimW-1:0]     torque_lim_i,
  input  wire logic [shc_pkg::StillLimW-1:0]      still_lim_i,
  output logic                                    homed_next_o,
  output shc_pkg::motor_state_t                   state_o
);

  localparam logic [shc_pkg::CountW-1:0] TicksTarget = shc_pkg::CountW'(StallTicks);

  logic [shc_pkg::CountW-1:0]    count_q, count_d, count_inc;
  logic                          homed_q, homed_d;
  logic                          openloop_q, openloop_d;
  logic signed [shc_pkg::AngleW-1:0] offset_q, offset_d;

  logic signed [shc_pkg::TorqueW:0] torque_ext;
  logic signed [shc_pkg::SpeedW:0]  speed_ext;
  logic [shc_pkg::TorqueW-1:0]      torque_mag;
  logic [shc_pkg::SpeedW-1:0]       speed_mag;
  logic                             pushing, still;

  // Magnitudes; one extra bit keeps the most negative code exact
  always_comb begin
    torque_ext = (shc_pkg::TorqueW+1)'(sample_i.torque);
    speed_ext  = (shc_pkg::SpeedW+1)'(sample_i.speed);
    if (torque_ext < 0) begin
      torque_ext = -torque_ext;
    end
    if (speed_ext < 0) begin
      speed_ext = -speed_ext;
    end
    torque_mag = torque_ext[shc_pkg::TorqueW-1:0];
    speed_mag  = speed_ext[shc_pkg::SpeedW-1:0];
    pushing    = torque_mag >= shc_pkg::TorqueW'(torque_lim_i);
    still      = speed_mag < shc_pkg::SpeedW'(still_lim_i);
    count_inc  = count_q + shc_pkg::CountW'(1);
  end

  // Next state for one tick
  always_comb begin
    count_d    = count_q;
    homed_d    = homed_q;
    openloop_d = openloop_q;
    offset_d   = offset_q;
    if (ctl_i.calibrating) begin
      if (sample_i.enabled && !homed_q) begin
        openloop_d = 1'b0;
        if (pushing && still) begin
          count_d = count_inc;
          if (count_inc >= TicksTarget) begin
            count_d    = '0;
            openloop_d = 1'b1;
            offset_d   = sample_i.angle;
            homed_d    = 1'b1;
          end
        end else begin
          count_d = '0;
        end
      end
    end else if (!sample_i.enabled) begin
      homed_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      homed_q    <= 1'b0;
      openloop_q <= 1'b0;
      offset_q   <= '0;
    end else if (ctl_i.step) begin
      count_q    <= count_d;
      homed_q    <= homed_d;
      openloop_q <= openloop_d;
      offset_q   <= offset_d;
    end
  end

  assign homed_next_o      = homed_d;
  assign state_o.homed     = homed_q;
  assign state_o.openloop  = openloop_q;
  assign state_o.offset    = offset_q;

endmodule

`default_nettype wire

// ===== rtl/stall_homing_calibrator.sv =====
// Top level of the sensorless stall homing calibrator for three motors.
//
// Usage:
//   in_i carries one control tick per word: enable, torque, speed and angle
//   for yaw, left pitch and right pitch. out_o returns one result word per
//   tick: phase, homed flags, drive modes and latched zero offsets.
//   Thresholds are set through cfg_we_i / cfg_idx_i / cfg_data_i while idle.
// Timing:
//   A taken word lands in the input register, is worked through the
//   per-motor compare/count logic, and its result is registered in the phase
//   and motor state registers, from which it is valid on out_o. One word per
//   cycle is sustained while out_o.ready stays high; the input register and
//   the result register form a two-stage pipeline with per-stage valid flags.
// Reset:
//   Asynchronous, active low. Phase goes to calibrating, all flags, counters
//   and offsets clear, torque thresholds to 0 and the stillness limit to 32.
// Stall:
//   While out_o.ready is low a pending result holds and the motor state freezes;
//   one more word is still taken into the input register, then in_i.ready
//   drops until the result is taken.
`default_nettype none

module stall_homing_calibrator #(
  parameter int unsigned StallTicks = shc_pkg::StallTicksDefault
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  shc_in_if.sink                                 in_i,
  shc_out_if.source                              out_o,
  input  wire logic                              cfg_we_i,
  input  wire logic [shc_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  wire logic [shc_pkg::CfgDataW-1:0]      cfg_data_i
);

  localparam int unsigned NMot = shc_pkg::MotorCount;

  // Configuration registers
  logic [shc_pkg::TorqueLimW-1:0] torque_lim_q [NMot];
  logic [shc_pkg::StillLimW-1:0]  still_lim_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NMot; i++) begin
        torque_lim_q[i] <= '0;
      end
      still_lim_q <= shc_pkg::StillLimReset;
    end else if (cfg_we_i) begin
      case (shc_pkg::cfg_idx_e'(cfg_idx_i))
        shc_pkg::CFG_TORQUE_YAW:
          torque_lim_q[shc_pkg::MotorYaw] <= cfg_data_i[shc_pkg::TorqueLimW-1:0];
        shc_pkg::CFG_TORQUE_PITCH_L:
          torque_lim_q[shc_pkg::MotorPitchL] <= cfg_data_i[shc_pkg::TorqueLimW-1:0];
        shc_pkg::CFG_TORQUE_PITCH_R:
          torque_lim_q[shc_pkg::MotorPitchR] <= cfg_data_i[shc_pkg::TorqueLimW-1:0];
        shc_pkg::CFG_STILL_LIMIT:
          still_lim_q <= cfg_data_i[shc_pkg::StillLimW-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline handshake
  logic in_vld_q, out_vld_q;
  logic advance, accept;

  assign advance     = in_vld_q && (!out_vld_q || out_o.ready);
  assign in_i.ready  = !in_vld_q || advance;
  assign accept      = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (accept) begin
        in_vld_q <= 1'b1;
      end else if (advance) begin
        in_vld_q <= 1'b0;
      end
      if (advance) begin
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Input word register
  shc_pkg::motor_in_t sample_q [NMot];
  shc_pkg::motor_in_t sample_d [NMot];

  always_comb begin
    sample_d[shc_pkg::MotorYaw]    = '{in_i.enabled_yaw, in_i.torque_yaw,
                                       in_i.speed_yaw, in_i.angle_yaw};
    sample_d[shc_pkg::MotorPitchL] = '{in_i.enabled_pitch_left, in_i.torque_pitch_left,
                                       in_i.speed_pitch_left, in_i.angle_pitch_left};
    sample_d[shc_pkg::MotorPitchR] = '{in_i.enabled_pitch_right, in_i.torque_pitch_right,
                                       in_i.speed_pitch_right, in_i.angle_pitch_right};
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      for (int i = 0; i < NMot; i++) begin
        sample_q[i] <= sample_d[i];
      end
    end
  end

  // Phase register
  logic                phase_q, phase_d;
  shc_pkg::motor_ctl_t ctl;
  logic [NMot-1:0]     homed_next;
  logic [NMot-1:0]     enabled;
  shc_pkg::motor_state_t mstate [NMot];

  assign ctl.step        = advance;
  assign ctl.calibrating = !phase_q;

  always_comb begin
    for (int i = 0; i < NMot; i++) begin
      enabled[i] = sample_q[i].enabled;
    end
    if (!phase_q) begin
      phase_d = &homed_next;
    end else begin
      phase_d = &enabled;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= 1'b0;
    end else if (advance) begin
      phase_q <= phase_d;
    end
  end

  // Motor units
  for (genvar g = 0; g < NMot; g++) begin : g_motor
    shc_motor #(
      .StallTicks (StallTicks)
    ) u_motor (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctl_i        (ctl),
      .sample_i     (sample_q[g]),
      .torque_lim_i (torque_lim_q[g]),
      .still_lim_i  (still_lim_q),
      .homed_next_o (homed_next[g]),
      .state_o      (mstate[g])
    );
  end

  // Result word; the state registers hold it while the receiver stalls
  assign out_o.valid                = out_vld_q;
  assign out_o.in_normal            = phase_q;
  assign out_o.homed_yaw            = mstate[shc_pkg::MotorYaw].homed;
  assign out_o.homed_pitch_left     = mstate[shc_pkg::MotorPitchL].homed;
  assign out_o.homed_pitch_right    = mstate[shc_pkg::MotorPitchR].homed;
  assign out_o.openloop_yaw         = mstate[shc_pkg::MotorYaw].openloop;
  assign out_o.openloop_pitch_left  = mstate[shc_pkg::MotorPitchL].openloop;
  assign out_o.openloop_pitch_right = mstate[shc_pkg::MotorPitchR].openloop;
  assign out_o.offset_yaw           = mstate[shc_pkg::MotorYaw].offset;
  assign out_o.offset_pitch_left    = mstate[shc_pkg::MotorPitchL].offset;
  assign out_o.offset_pitch_right   = mstate[shc_pkg::MotorPitchR].offset;

endmodule

`default_nettype wire

// ===== rtl/shc_checker.sv =====
// Port-level assertions for the stall homing calibrator, with its bind.
`default_nettype none

module shc_checker (
  input wire logic                              clk_i,
  input wire logic                              rst_ni,
  input wire logic                              out_valid,
  input wire logic                              out_ready,
  input wire logic                              in_normal,
  input wire logic [shc_pkg::MotorCount-1:0]    homed,
  input wire logic [shc_pkg::MotorCount-1:0]    openloop,
  input wire logic [3*shc_pkg::AngleW-1:0]      offsets
);

  // A pending result word stays until taken
  a_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid)
    else $error("result valid dropped while stalled");

  // A stalled result word keeps its payload
  a_payload_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=>
      $stable(in_normal) && $stable(homed) && $stable(openloop) && $stable(offsets))
    else $error("result payload changed while stalled");

  // Normal phase only with every motor homed
  a_normal_homed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && in_normal |-> (&homed))
    else $error("normal phase with a motor not homed");

  // A homed motor sits in open loop
  a_homed_openloop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> ((homed & ~openloop) == '0))
    else $error("homed motor not in open loop");

endmodule

bind stall_homing_calibrator shc_checker u_shc_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .out_valid (out_o.valid),
  .out_ready (out_o.ready),
  .in_normal (out_o.in_normal),
  .homed     ({out_o.homed_pitch_right, out_o.homed_pitch_left, out_o.homed_yaw}),
  .openloop  ({out_o.openloop_pitch_right, out_o.openloop_pitch_left, out_o.openloop_yaw}),
  .offsets   ({out_o.offset_pitch_right, out_o.offset_pitch_left, out_o.offset_yaw})
);

`default_nettype wire
